@@ sv/cds_pkg.sv @@
// Package for the calendar date shift block.
// Holds field widths, command codes, state codes and the Gregorian month table.
// No dependencies.
package cds_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DELTA_W = 21;
  // Day offset within a month plus the largest delta, with headroom for one carry.
  localparam int unsigned ACC_W   = 23;
  localparam int unsigned Y400_W  = 9;

  localparam int unsigned MAX_YEAR   = 9999;
  localparam int unsigned YEAR_CYCLE = 400;
  localparam int unsigned CENTURY    = 100;
  localparam int unsigned LAST_MONTH = 12;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SHIFT = 2'd1,
    CMD_CMP   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_CHECK  = 6'b000100,
    S_INIT   = 6'b001000,
    S_WALK   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  // Leap test on the year taken modulo 400.
  function automatic logic is_leap(input logic [Y400_W-1:0] y400);
    logic four;
    logic cent;
    four = (y400[1:0] == 2'b00);
    cent = (y400 == Y400_W'(CENTURY)) || (y400 == Y400_W'(2 * CENTURY)) ||
           (y400 == Y400_W'(3 * CENTURY));
    return four && !cent;
  endfunction

  // Length of a month; months outside 1..12 have length zero.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

@@ sv/calendar_date_shift.sv @@
// Top level of the calendar date shift block: sequencer, held date and result register.
// Depends on cds_pkg and cds_addsub.

// The block holds one Gregorian date (years 0 to 9999, year 0 a leap year) and
// answers every input beat with exactly one result beat carrying the held date.
// Load reduces the year modulo 400 by repeated subtraction in the shared adder,
// one step per cycle, to settle the leap rule. Shift takes that reduction (at
// most 25 steps for a held year up to 9999) and then walks the offset month by
// month in either direction in the shared adder. Compare and the unused command
// code skip the adder and go straight to the done state. Input stall is high
// while an item is in work; a finished result waits in the output register.
module calendar_date_shift (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       cmd_i,
  input  logic [cds_pkg::YEAR_W-1:0]       date_year_i,
  input  logic [cds_pkg::MONTH_W-1:0]      date_month_i,
  input  logic [cds_pkg::DAY_W-1:0]        date_day_i,
  input  logic signed [cds_pkg::DELTA_W-1:0] day_delta_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cds_pkg::YEAR_W-1:0]       cur_year_o,
  output logic [cds_pkg::MONTH_W-1:0]      cur_month_o,
  output logic [cds_pkg::DAY_W-1:0]        cur_day_o,
  output logic                             is_later_o,
  output logic                             is_equal_o,
  output logic                             rejected_o
);

  localparam int unsigned YW  = cds_pkg::YEAR_W;
  localparam int unsigned MW  = cds_pkg::MONTH_W;
  localparam int unsigned DW  = cds_pkg::DAY_W;
  localparam int unsigned AW  = cds_pkg::ACC_W;
  localparam int unsigned QW  = cds_pkg::Y400_W;

  cds_pkg::state_e state_q, state_d;

  logic [YW-1:0] held_year_q, held_year_d;
  logic [MW-1:0] held_month_q, held_month_d;
  logic [DW-1:0] held_day_q, held_day_d;

  cds_pkg::cmd_e                       cmd_q, cmd_d;
  logic [YW-1:0]                       cap_year_q, cap_year_d;
  logic [MW-1:0]                       cap_month_q, cap_month_d;
  logic [DW-1:0]                       cap_day_q, cap_day_d;
  logic signed [cds_pkg::DELTA_W-1:0]  delta_q, delta_d;

  logic [YW-1:0]        acc_q, acc_d;
  logic signed [AW-1:0] r_q, r_d;
  logic [YW-1:0]        wy_q, wy_d;
  logic [MW-1:0]        wm_q, wm_d;
  logic [QW-1:0]        y400_q, y400_d;

  logic later_q, later_d, equal_q, equal_d, rej_q, rej_d;

  logic          out_valid_q, out_valid_d;
  logic [YW-1:0] out_year_q, out_year_d;
  logic [MW-1:0] out_month_q, out_month_d;
  logic [DW-1:0] out_day_q, out_day_d;
  logic          out_later_q, out_later_d, out_equal_q, out_equal_d, out_rej_q, out_rej_d;

  logic signed [AW-1:0] alu_a, alu_b, alu_sum;
  logic                 alu_sub, alu_neg;

  logic [MW-1:0] prev_month;
  logic [DW-1:0] cur_len, prev_len, cap_len, day_m1;
  logic          leap_w, load_ok;

  cds_addsub u_addsub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .neg_o (alu_neg)
  );

  assign leap_w     = cds_pkg::is_leap(y400_q);
  assign prev_month = (wm_q == MW'(1)) ? MW'(cds_pkg::LAST_MONTH) : (wm_q - MW'(1));
  assign cur_len    = cds_pkg::month_len(wm_q, leap_w);
  assign prev_len   = cds_pkg::month_len(prev_month, leap_w);
  assign cap_len    = cds_pkg::month_len(cap_month_q, cds_pkg::is_leap(acc_q[QW-1:0]));
  assign day_m1     = held_day_q - DW'(1);
  assign load_ok    = (cap_year_q <= YW'(cds_pkg::MAX_YEAR)) &&
                      (cap_month_q != '0) && (cap_month_q <= MW'(cds_pkg::LAST_MONTH)) &&
                      (cap_day_q != '0) && (cap_day_q <= cap_len);

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = r_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      cds_pkg::S_REDUCE: begin
        alu_a   = {{(AW-YW){1'b0}}, acc_q};
        alu_b   = AW'(cds_pkg::YEAR_CYCLE);
        alu_sub = 1'b1;
      end
      cds_pkg::S_INIT: begin
        alu_a   = AW'(delta_q);
        alu_b   = {{(AW-DW){1'b0}}, day_m1};
        alu_sub = 1'b0;
      end
      cds_pkg::S_WALK: begin
        alu_a = r_q;
        if (r_q[AW-1]) begin
          alu_b   = {{(AW-DW){1'b0}}, prev_len};
          alu_sub = 1'b0;
        end else begin
          alu_b   = {{(AW-DW){1'b0}}, cur_len};
          alu_sub = 1'b1;
        end
      end
      default: begin
        alu_a   = r_q;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    held_year_d  = held_year_q;
    held_month_d = held_month_q;
    held_day_d   = held_day_q;
    cmd_d        = cmd_q;
    cap_year_d   = cap_year_q;
    cap_month_d  = cap_month_q;
    cap_day_d    = cap_day_q;
    delta_d      = delta_q;
    acc_d        = acc_q;
    r_d          = r_q;
    wy_d         = wy_q;
    wm_d         = wm_q;
    y400_d       = y400_q;
    later_d      = later_q;
    equal_d      = equal_q;
    rej_d        = rej_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_year_d   = out_year_q;
    out_month_d  = out_month_q;
    out_day_d    = out_day_q;
    out_later_d  = out_later_q;
    out_equal_d  = out_equal_q;
    out_rej_d    = out_rej_q;

    unique case (state_q)
      cds_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = cds_pkg::cmd_e'(cmd_i);
          cap_year_d  = date_year_i;
          cap_month_d = date_month_i;
          cap_day_d   = date_day_i;
          delta_d     = day_delta_i;
          later_d     = 1'b0;
          equal_d     = 1'b0;
          rej_d       = 1'b0;
          unique case (cds_pkg::cmd_e'(cmd_i))
            cds_pkg::CMD_LOAD: begin
              acc_d   = date_year_i;
              state_d = cds_pkg::S_REDUCE;
            end
            cds_pkg::CMD_SHIFT: begin
              acc_d   = held_year_q;
              state_d = cds_pkg::S_REDUCE;
            end
            cds_pkg::CMD_CMP: begin
              later_d = (held_year_q > date_year_i) ||
                        ((held_year_q == date_year_i) &&
                         ((held_month_q > date_month_i) ||
                          ((held_month_q == date_month_i) && (held_day_q > date_day_i))));
              equal_d = (held_year_q == date_year_i) && (held_month_q == date_month_i) &&
                        (held_day_q == date_day_i);
              state_d = cds_pkg::S_DONE;
            end
            cds_pkg::CMD_NOP: begin
              state_d = cds_pkg::S_DONE;
            end
          endcase
        end
      end
      cds_pkg::S_REDUCE: begin
        if (!alu_neg) begin
          acc_d = alu_sum[YW-1:0];
        end else if (cmd_q == cds_pkg::CMD_LOAD) begin
          state_d = cds_pkg::S_CHECK;
        end else begin
          state_d = cds_pkg::S_INIT;
        end
      end
      cds_pkg::S_CHECK: begin
        if (load_ok) begin
          held_year_d  = cap_year_q;
          held_month_d = cap_month_q;
          held_day_d   = cap_day_q;
        end
        rej_d   = !load_ok;
        state_d = cds_pkg::S_DONE;
      end
      cds_pkg::S_INIT: begin
        r_d     = alu_sum;
        wy_d    = held_year_q;
        wm_d    = held_month_q;
        y400_d  = acc_q[QW-1:0];
        state_d = cds_pkg::S_WALK;
      end
      cds_pkg::S_WALK: begin
        if (r_q[AW-1]) begin
          // Step back into the previous month; January of year 0 has nowhere to go.
          if ((wm_q == MW'(1)) && (wy_q == '0)) begin
            rej_d   = 1'b1;
            state_d = cds_pkg::S_DONE;
          end else begin
            r_d  = alu_sum;
            wm_d = prev_month;
            if (wm_q == MW'(1)) begin
              wy_d   = wy_q - YW'(1);
              y400_d = (y400_q == '0) ? QW'(cds_pkg::YEAR_CYCLE - 1) : (y400_q - QW'(1));
            end
          end
        end else if (!alu_neg) begin
          // Offset runs past this month: carry into the next one.
          if ((wm_q == MW'(cds_pkg::LAST_MONTH)) && (wy_q == YW'(cds_pkg::MAX_YEAR))) begin
            rej_d   = 1'b1;
            state_d = cds_pkg::S_DONE;
          end else begin
            r_d = alu_sum;
            if (wm_q == MW'(cds_pkg::LAST_MONTH)) begin
              wm_d   = MW'(1);
              wy_d   = wy_q + YW'(1);
              y400_d = (y400_q == QW'(cds_pkg::YEAR_CYCLE - 1)) ? '0 : (y400_q + QW'(1));
            end else begin
              wm_d = wm_q + MW'(1);
            end
          end
        end else begin
          held_year_d  = wy_q;
          held_month_d = wm_q;
          held_day_d   = r_q[DW-1:0] + DW'(1);
          state_d      = cds_pkg::S_DONE;
        end
      end
      cds_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_year_d  = held_year_q;
          out_month_d = held_month_q;
          out_day_d   = held_day_q;
          out_later_d = later_q;
          out_equal_d = equal_q;
          out_rej_d   = rej_q;
          state_d     = cds_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cds_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cds_pkg::S_IDLE;
      held_year_q  <= '0;
      held_month_q <= MW'(1);
      held_day_q   <= DW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_year_q  <= held_year_d;
      held_month_q <= held_month_d;
      held_day_q   <= held_day_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cap_year_q  <= cap_year_d;
    cap_month_q <= cap_month_d;
    cap_day_q   <= cap_day_d;
    delta_q     <= delta_d;
    acc_q       <= acc_d;
    r_q         <= r_d;
    wy_q        <= wy_d;
    wm_q        <= wm_d;
    y400_q      <= y400_d;
    later_q     <= later_d;
    equal_q     <= equal_d;
    rej_q       <= rej_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    out_later_q <= out_later_d;
    out_equal_q <= out_equal_d;
    out_rej_q   <= out_rej_d;
  end

  assign in_stall_o  = (state_q != cds_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cur_year_o  = out_year_q;
  assign cur_month_o = out_month_q;
  assign cur_day_o   = out_day_q;
  assign is_later_o  = out_later_q;
  assign is_equal_o  = out_equal_q;
  assign rejected_o  = out_rej_q;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != cds_pkg::S_IDLE))
    else $error("accepted beat did not start work");

  a_held_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_year_q <= YW'(cds_pkg::MAX_YEAR)) && (held_month_q != '0) &&
    (held_month_q <= MW'(cds_pkg::LAST_MONTH)) && (held_day_q != '0))
    else $error("held date left its legal range");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_later_q && out_equal_q) && !(out_rej_q && (out_later_q || out_equal_q)))
    else $error("result flags contradict each other");

  a_reject_keeps_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == cds_pkg::S_WALK) && (state_d == cds_pkg::S_DONE) && rej_d) |=>
    $stable(held_year_q) && $stable(held_month_q) && $stable(held_day_q))
    else $error("rejected shift changed the held date");
`endif

endmodule

@@ sv/cds_addsub.sv @@
// Shared add/subtract unit of the calendar date shift block.
// Depends on cds_pkg for the datapath width.
module cds_addsub (
  input  logic signed [cds_pkg::ACC_W-1:0] a_i,
  input  logic signed [cds_pkg::ACC_W-1:0] b_i,
  input  logic                             sub_i,
  output logic signed [cds_pkg::ACC_W-1:0] sum_o,
  output logic                             neg_o
);

  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign neg_o = sum_o[cds_pkg::ACC_W-1];

endmodule
